// File: src/als_pkg.sv
// Shared types and constants for the acquisition lock sequencer.
// No dependencies; compile first.
`timescale 1ns / 1ps

package als_pkg;

	// Default widths of the time base and the good-frame counter.
	localparam int ALS_TIME_BITS  = 32;
	localparam int ALS_COUNT_BITS = 8;

	// Configuration port geometry.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;

	// Register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] REG_COARSE_BUDGET = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CODE_BUDGET   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SHAPE_BUDGET  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STABLE_HOLD   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOTAL_BUDGET  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CAND_FRAMES   = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SHAPE_FRAMES  = 3'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_FRAMES  = 3'd7;

	// Controller states.
	localparam logic [3:0] S_ENTER  = 4'd0;
	localparam logic [3:0] S_GRID   = 4'd1;
	localparam logic [3:0] S_COARSE = 4'd2;
	localparam logic [3:0] S_CODE   = 4'd3;
	localparam logic [3:0] S_CAND   = 4'd4;
	localparam logic [3:0] S_SHAPE  = 4'd5;
	localparam logic [3:0] S_PHASE  = 4'd6;
	localparam logic [3:0] S_STABLE = 4'd7;
	localparam logic [3:0] S_FAILED = 4'd8;

	// Event codes.
	localparam logic [3:0] E_NONE    = 4'd0;
	localparam logic [3:0] E_MODE    = 4'd1;
	localparam logic [3:0] E_SRC     = 4'd2;
	localparam logic [3:0] E_TOTAL   = 4'd3;
	localparam logic [3:0] E_STAGE   = 4'd4;
	localparam logic [3:0] E_GRID    = 4'd5;
	localparam logic [3:0] E_COARSE  = 4'd6;
	localparam logic [3:0] E_CODE    = 4'd7;
	localparam logic [3:0] E_CAND    = 4'd8;
	localparam logic [3:0] E_REJECT  = 4'd9;
	localparam logic [3:0] E_SHAPE   = 4'd10;
	localparam logic [3:0] E_PHASE   = 4'd11;
	localparam logic [3:0] E_STSTART = 4'd12;
	localparam logic [3:0] E_STRESET = 4'd13;
	localparam logic [3:0] E_PASS    = 4'd14;

	// Smallest passing frequency margin in Q4.12 (0.01 rounded up).
	localparam logic signed [15:0] MARGIN_MIN = 16'sd41;

	typedef struct packed {
		logic [31:0] coarse_ticks;
		logic [31:0] code_ticks;
		logic [31:0] shape_ticks;
		logic [31:0] hold_ticks;
		logic [31:0] total_budget;
		logic [7:0]  cand_frames;
		logic [7:0]  shape_frames;
		logic [7:0]  phase_frames;
	} cfg_t;

	typedef struct packed {
		logic               func;
		logic [31:0]        now_ticks;
		logic               src_change;
		logic               grid_rdy;
		logic               coarse_found;
		logic               freq_code_ready;
		logic signed [15:0] freq_margin;
		logic               shape_ok;
		logic               phase_ok;
	} in_item_t;

	typedef struct packed {
		logic [3:0] state_code;
		logic [3:0] event_code;
		logic       freq_probe_request;
		logic       phase_track_allow;
		logic       stable_flag;
		logic       failed_flag;
	} out_item_t;

endpackage

// File: src/als_if.sv
// Valid/ready channel interfaces for observation frames and results.
// Depends on als_pkg for the payload types.
`timescale 1ns / 1ps

interface als_in_if import als_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface als_out_if import als_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/als_cfg_regs.sv
// Configuration register bank: write-only, indexed, reset to defaults.
// Depends on als_pkg.
`timescale 1ns / 1ps

module als_cfg_regs import als_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coarse_ticks <= '0;
			cfg_q.code_ticks   <= '0;
			cfg_q.shape_ticks  <= '0;
			cfg_q.hold_ticks   <= '0;
			cfg_q.total_budget <= '0;
			cfg_q.cand_frames  <= 8'd1;
			cfg_q.shape_frames <= 8'd1;
			cfg_q.phase_frames <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COARSE_BUDGET: cfg_q.coarse_ticks <= cfg_data;
				REG_CODE_BUDGET:   cfg_q.code_ticks   <= cfg_data;
				REG_SHAPE_BUDGET:  cfg_q.shape_ticks  <= cfg_data;
				REG_STABLE_HOLD:   cfg_q.hold_ticks   <= cfg_data;
				REG_TOTAL_BUDGET:  cfg_q.total_budget <= cfg_data;
				REG_CAND_FRAMES:   cfg_q.cand_frames  <= cfg_data[7:0];
				REG_SHAPE_FRAMES:  cfg_q.shape_frames <= cfg_data[7:0];
				REG_PHASE_FRAMES:  cfg_q.phase_frames <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/als_step_core.sv
// Sequencer state and combinational step logic for one observation frame.
// Depends on als_pkg.
`timescale 1ns / 1ps

module als_step_core import als_pkg::*; #(
	parameter int TIME_BITS  = ALS_TIME_BITS,
	parameter int COUNT_BITS = ALS_COUNT_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t res
);

	// Compare widths wide enough for the time base and 32-bit budgets, and for the count and 8-bit frame counts.
	localparam int WIDE_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;
	localparam int CMP_BITS  = (COUNT_BITS > 8) ? COUNT_BITS : 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [3:0]            st_q, st_d;
	logic [TIME_BITS-1:0]  start_q, start_d;
	logic [TIME_BITS-1:0]  deadline_q, deadline_d;
	logic [TIME_BITS-1:0]  hold_q, hold_d;
	logic [COUNT_BITS-1:0] gc_q, gc_d;
	logic [3:0]            pend_q, pend_d;

	logic [TIME_BITS-1:0]  now;
	logic [TIME_BITS-1:0]  stage_diff;
	logic [TIME_BITS-1:0]  total_diff;
	logic [TIME_BITS-1:0]  hold_diff;
	logic [COUNT_BITS-1:0] gc_inc;
	logic                  freq_good;
	logic                  total_over;
	logic                  stage_over;
	logic                  hold_done;

	assign now        = TIME_BITS'(item.now_ticks);
	assign stage_diff = now - deadline_q;
	assign total_diff = now - start_q;
	assign hold_diff  = now - hold_q;
	assign gc_inc     = (gc_q == COUNT_MAX) ? gc_q : gc_q + 1'b1;
	assign freq_good  = item.freq_code_ready && (item.freq_margin >= MARGIN_MIN);
	assign total_over = WIDE_BITS'(total_diff) > WIDE_BITS'(cfg.total_budget);
	assign stage_over = (stage_diff != '0) && !stage_diff[TIME_BITS-1];
	assign hold_done  = WIDE_BITS'(hold_diff) >= WIDE_BITS'(cfg.hold_ticks);

	always_comb begin
		logic       go;
		logic [3:0] go_st;
		logic [3:0] go_ev;
		logic [3:0] ev;
		logic       probe;
		logic       allow;
		logic       stable;

		st_d       = st_q;
		start_d    = start_q;
		deadline_d = deadline_q;
		hold_d     = hold_q;
		gc_d       = gc_q;
		pend_d     = E_NONE;
		go         = 1'b0;
		go_st      = st_q;
		go_ev      = E_NONE;
		ev         = pend_q;
		probe      = 1'b0;
		allow      = 1'b0;
		stable     = 1'b0;
		res        = '0;

		if (item.func) begin
			// Restart: everything back to mode enter, event reported next frame.
			st_d    = S_ENTER;
			start_d = now;
			hold_d  = '0;
			gc_d    = '0;
			pend_d  = E_MODE;
		end else begin
			if (item.src_change && st_q != S_ENTER) begin
				go = 1'b1; go_st = S_COARSE; go_ev = E_SRC;
				ev = E_SRC;
				probe = 1'b1;
			end else if (total_over && st_q != S_STABLE) begin
				go = 1'b1; go_st = S_FAILED; go_ev = E_TOTAL;
				ev = E_TOTAL;
			end else if (st_q != S_ENTER && st_q != S_FAILED && st_q != S_STABLE
			             && stage_over) begin
				go = 1'b1; go_st = S_FAILED; go_ev = E_STAGE;
				ev = E_STAGE;
			end else begin
				unique case (st_q)
					S_ENTER: begin
						if (item.grid_rdy) begin
							go = 1'b1; go_st = S_GRID; go_ev = E_GRID;
						end
					end
					S_GRID: begin
						go = 1'b1; go_st = S_COARSE; go_ev = E_COARSE;
					end
					S_COARSE: begin
						probe = 1'b1;
						if (item.coarse_found) begin
							go = 1'b1; go_st = S_CODE; go_ev = E_CODE;
						end
					end
					S_CODE: begin
						probe = 1'b1;
						if (freq_good) begin
							gc_d = gc_inc;
							if (CMP_BITS'(gc_inc) >= CMP_BITS'(cfg.cand_frames)) begin
								go = 1'b1; go_st = S_CAND; go_ev = E_CAND;
							end
						end else begin
							gc_d = '0;
						end
					end
					S_CAND: begin
						if (freq_good) begin
							gc_d = gc_inc;
							if (CMP_BITS'(gc_inc) >= CMP_BITS'(cfg.cand_frames)) begin
								go = 1'b1; go_st = S_SHAPE; go_ev = E_SHAPE;
							end
						end else begin
							go = 1'b1; go_st = S_CODE; go_ev = E_REJECT;
						end
					end
					S_SHAPE: begin
						if (item.shape_ok) begin
							gc_d = gc_inc;
							if (CMP_BITS'(gc_inc) >= CMP_BITS'(cfg.shape_frames)) begin
								go = 1'b1; go_st = S_PHASE; go_ev = E_PHASE;
							end
						end else begin
							gc_d = '0;
						end
					end
					S_PHASE: begin
						allow = 1'b1;
						if (item.phase_ok) begin
							gc_d = gc_inc;
							if (CMP_BITS'(gc_inc) >= CMP_BITS'(cfg.phase_frames)) begin
								go = 1'b1; go_st = S_STABLE; go_ev = E_STSTART;
							end
						end else begin
							gc_d = '0;
						end
					end
					S_STABLE: begin
						allow = 1'b1;
						if (!item.shape_ok || !item.phase_ok) begin
							go = 1'b1; go_st = S_PHASE; go_ev = E_STRESET;
						end else if (hold_done) begin
							stable = 1'b1;
							ev = E_PASS;
						end
					end
					default: ;
				endcase
			end

			// Take the transition: clear the run count; arm the new deadline (none for failed) and, for stable, the hold start.
			if (go) begin
				st_d   = go_st;
				gc_d   = '0;
				pend_d = go_ev;
				case (go_st)
					S_GRID, S_COARSE: deadline_d = now + TIME_BITS'(cfg.coarse_ticks);
					S_CODE, S_CAND:   deadline_d = now + TIME_BITS'(cfg.code_ticks);
					S_SHAPE, S_PHASE: deadline_d = now + TIME_BITS'(cfg.shape_ticks);
					S_STABLE: begin
						hold_d     = now;
						deadline_d = now + TIME_BITS'(cfg.hold_ticks);
					end
					default: ;
				endcase
			end

			res.state_code         = st_d;
			res.event_code         = ev;
			res.freq_probe_request = probe;
			res.phase_track_allow  = allow;
			res.stable_flag        = stable;
			res.failed_flag        = (st_d == S_FAILED);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_ENTER;
			start_q    <= '0;
			deadline_q <= '0;
			hold_q     <= '0;
			gc_q       <= '0;
			pend_q     <= E_MODE;
		end else if (step) begin
			st_q       <= st_d;
			start_q    <= start_d;
			deadline_q <= deadline_d;
			hold_q     <= hold_d;
			gc_q       <= gc_d;
			pend_q     <= pend_d;
		end
	end

endmodule

// File: src/acquisition_lock_sequencer.sv
// Top level of the acquisition lock sequencer: input register, step core,
// result register and configuration bank. Depends on als_pkg, als_if,
// als_cfg_regs and als_step_core.
//
//   channel   direction  handshake     payload
//   in_ch     sink       valid/ready   in_item_t  (one observation frame)
//   out_ch    source     valid/ready   out_item_t (one result per frame)
//   cfg_*     input      cfg_we only   index 3 bits, data 32 bits
//
// Each frame is held in the input register, where the step logic reads it against
// the sequencer state; its result is then registered in the output register.
// One frame per cycle is sustained while out_ch is ready.
// A stalled output holds its result while the input register holds the next
// frame; ready drops only when both are full.
// Reset clears the sequencer to mode enter with the mode enter event pending.
`timescale 1ns / 1ps

module acquisition_lock_sequencer import als_pkg::*; #(
	parameter int TIME_BITS  = ALS_TIME_BITS,
	parameter int COUNT_BITS = ALS_COUNT_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	als_in_if.sink                    in_ch,
	als_out_if.source                 out_ch,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;
	logic      advance;

	// Advance the frame in the input register whenever the result slot is free
	// or is being emptied this cycle.
	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	als_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// State moves only when the frame actually advances, so a stall leaves
	// the sequencer untouched.
	als_step_core #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Input register: capture a frame on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.data;
		end
	end

	// Result register: load on advance, drop valid once the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

endmodule

// File: bench/als_sequence_checker.sv
// Result checker for the acquisition lock sequencer: watches both channels and the
// register port, predicts every result and compares it. Depends on als_pkg and als_if.
`timescale 1ns / 1ps

module als_sequence_checker import als_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	als_in_if                         in_ch,
	als_out_if                        out_ch,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output int                        fail_count,
	output int                        outstanding
);

	cfg_t        budgets;
	logic [3:0]  seq_state;
	logic [3:0]  queued_event;
	logic [31:0] t_start;
	logic [31:0] t_deadline;
	logic [31:0] t_hold;
	logic [7:0]  run_len;
	out_item_t   expected_results[$];
	out_item_t   want;
	int          errors;

	function automatic void move_to(input logic [3:0] st, input logic [31:0] now,
			input logic [3:0] ev);
		seq_state    = st;
		run_len      = '0;
		queued_event = ev;
		case (st)
		S_GRID, S_COARSE: t_deadline = now + budgets.coarse_ticks;
		S_CODE, S_CAND:   t_deadline = now + budgets.code_ticks;
		S_SHAPE, S_PHASE: t_deadline = now + budgets.shape_ticks;
		S_STABLE: begin
			t_hold     = now;
			t_deadline = now + budgets.hold_ticks;
		end
		default: ;
		endcase
	endfunction

	// Count one more good frame, saturating, and tell whether the run is long enough.
	function automatic logic count_run(input logic [7:0] need);
		if (run_len != 8'hFF)
			run_len = run_len + 8'd1;
		return run_len >= need;
	endfunction

	function automatic out_item_t step_sequencer(input in_item_t f);
		out_item_t   r;
		logic [31:0] now;
		logic [31:0] lag;
		logic [31:0] elapsed;
		logic [31:0] held;
		logic        freq_good;
		r         = '0;
		now       = f.now_ticks;
		freq_good = f.freq_code_ready && ($signed(f.freq_margin) >= MARGIN_MIN);
		if (f.func) begin
			seq_state    = S_ENTER;
			t_start      = now;
			t_hold       = '0;
			run_len      = '0;
			queued_event = E_MODE;
			return r;
		end
		r.event_code = queued_event;
		queued_event = E_NONE;
		lag          = now - t_deadline;
		elapsed      = now - t_start;
		held         = now - t_hold;
		if (f.src_change && seq_state != S_ENTER) begin
			move_to(S_COARSE, now, E_SRC);
			r.event_code         = E_SRC;
			r.freq_probe_request = 1'b1;
		end else if (elapsed > budgets.total_budget && seq_state != S_STABLE) begin
			move_to(S_FAILED, now, E_TOTAL);
			r.event_code = E_TOTAL;
		end else if (seq_state != S_ENTER && seq_state != S_FAILED && seq_state != S_STABLE
				&& lag != '0 && !lag[31]) begin
			move_to(S_FAILED, now, E_STAGE);
			r.event_code = E_STAGE;
		end else begin
			case (seq_state)
			S_ENTER: if (f.grid_rdy) move_to(S_GRID, now, E_GRID);
			S_GRID:  move_to(S_COARSE, now, E_COARSE);
			S_COARSE: begin
				r.freq_probe_request = 1'b1;
				if (f.coarse_found)
					move_to(S_CODE, now, E_CODE);
			end
			S_CODE: begin
				r.freq_probe_request = 1'b1;
				if (!freq_good)
					run_len = '0;
				else if (count_run(budgets.cand_frames))
					move_to(S_CAND, now, E_CAND);
			end
			S_CAND: begin
				if (!freq_good)
					move_to(S_CODE, now, E_REJECT);
				else if (count_run(budgets.cand_frames))
					move_to(S_SHAPE, now, E_SHAPE);
			end
			S_SHAPE: begin
				if (!f.shape_ok)
					run_len = '0;
				else if (count_run(budgets.shape_frames))
					move_to(S_PHASE, now, E_PHASE);
			end
			S_PHASE: begin
				r.phase_track_allow = 1'b1;
				if (!f.phase_ok)
					run_len = '0;
				else if (count_run(budgets.phase_frames))
					move_to(S_STABLE, now, E_STSTART);
			end
			S_STABLE: begin
				r.phase_track_allow = 1'b1;
				if (!f.shape_ok || !f.phase_ok) begin
					move_to(S_PHASE, now, E_STRESET);
				end else if (held >= budgets.hold_ticks) begin
					r.stable_flag = 1'b1;
					r.event_code  = E_PASS;
				end
			end
			default: ;
			endcase
		end
		r.state_code  = seq_state;
		r.failed_flag = (seq_state == S_FAILED);
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_val,
			input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, actual %0d", name, exp_val, act_val);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budgets      = '0;
			budgets.cand_frames  = 8'd1;
			budgets.shape_frames = 8'd1;
			budgets.phase_frames = 8'd1;
			seq_state    = S_ENTER;
			queued_event = E_MODE;
			t_start      = '0;
			t_deadline   = '0;
			t_hold       = '0;
			run_len      = '0;
			expected_results.delete();
			errors       = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no frame waiting for it");
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("state_code", want.state_code, out_ch.data.state_code);
					check_field("event_code", want.event_code, out_ch.data.event_code);
					check_field("freq_probe_request", want.freq_probe_request,
						out_ch.data.freq_probe_request);
					check_field("phase_track_allow", want.phase_track_allow,
						out_ch.data.phase_track_allow);
					check_field("stable_flag", want.stable_flag, out_ch.data.stable_flag);
					check_field("failed_flag", want.failed_flag, out_ch.data.failed_flag);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				REG_COARSE_BUDGET: budgets.coarse_ticks = cfg_data;
				REG_CODE_BUDGET:   budgets.code_ticks   = cfg_data;
				REG_SHAPE_BUDGET:  budgets.shape_ticks  = cfg_data;
				REG_STABLE_HOLD:   budgets.hold_ticks   = cfg_data;
				REG_TOTAL_BUDGET:  budgets.total_budget = cfg_data;
				REG_CAND_FRAMES:   budgets.cand_frames  = cfg_data[7:0];
				REG_SHAPE_FRAMES:  budgets.shape_frames = cfg_data[7:0];
				REG_PHASE_FRAMES:  budgets.phase_frames = cfg_data[7:0];
				default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(step_sequencer(in_ch.data));
			fail_count  <= errors;
			outstanding <= expected_results.size();
		end
	end

endmodule

// File: bench/tb_acquisition_lock_sequencer.sv
// Testbench top for the acquisition lock sequencer: clock, reset, frame and register
// stimulus and the verdict. Depends on als_pkg, als_if, the block and als_sequence_checker.
`timescale 1ns / 1ps

module tb_acquisition_lock_sequencer import als_pkg::*; ();

	localparam int    HOLD_OFF_CYCLES = 150;
	localparam int    SETTLE_CYCLES   = 4;
	localparam longint WATCHDOG_NS    = 5_000_000;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int                        fail_count;
	int                        outstanding;

	// Running timestamp of the well-formed frames.
	logic [31:0] tick;
	// Ask the result side for one long hold-off while frames keep coming.
	bit          hold_off_req;
	// Turn idling off on both sides.
	bit          quiet;

	als_in_if  in_ch ();
	als_out_if out_ch ();

	acquisition_lock_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	als_sequence_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the handshakes hang.
	initial begin
		#(WATCHDOG_NS);
		$display("tb_acquisition_lock_sequencer failed");
		$finish;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t make_frame(input logic func, input logic [31:0] now,
			input logic src, input logic grid, input logic coarse, input logic code,
			input logic [15:0] margin, input logic shape, input logic phase);
		in_item_t f;
		f.func            = func;
		f.now_ticks       = now;
		f.src_change      = src;
		f.grid_rdy        = grid;
		f.coarse_found    = coarse;
		f.freq_code_ready = code;
		f.freq_margin     = margin;
		f.shape_ok        = shape;
		f.phase_ok        = phase;
		return f;
	endfunction

	// Build one frame: noise, or a well-formed frame whose flags pass with good_pct and
	// whose restarts, source changes and time jumps come with upset_pct.
	function automatic in_item_t random_frame(input int good_pct, input int noise_pct,
			input int upset_pct);
		in_item_t f;
		int       roll;
		if (chance(noise_pct)) begin
			f = in_item_t'($bits(in_item_t)'({$urandom(), $urandom()}));
			return f;
		end
		f.func            = chance(upset_pct);
		f.src_change      = chance(upset_pct);
		f.grid_rdy        = chance(good_pct);
		f.coarse_found    = chance(good_pct);
		f.freq_code_ready = chance(good_pct);
		f.shape_ok        = chance(good_pct);
		f.phase_ok        = chance(good_pct);
		if (chance(good_pct)) begin
			f.freq_margin = 16'($urandom_range(41, 32767));
		end else begin
			case ($urandom_range(0, 3))
			0:       f.freq_margin = 16'd40;
			1:       f.freq_margin = 16'h8000;
			2:       f.freq_margin = 16'($urandom_range(0, 40));
			default: f.freq_margin = {1'b1, 15'($urandom())};
			endcase
		end
		roll = $urandom_range(0, 99);
		if (roll < upset_pct)
			tick = tick + $urandom();
		else if (roll < 80)
			tick = tick + $urandom_range(0, 2);
		else
			tick = tick + $urandom_range(3, 30);
		f.now_ticks = tick;
		return f;
	endfunction

	// Offer one frame and hold it until the block takes the transaction.
	task automatic send_frame(input in_item_t f);
		int gap;
		in_ch.data  <= f;
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		gap = (quiet || hold_off_req) ? 0 : pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid, wait for every predicted result, then let the pipeline go quiet.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all eight registers back to back; the frame counts sometimes carry
	// junk in the upper bits, which the block must drop.
	task automatic program_budgets(input cfg_t c);
		logic [CFG_INDEX_BITS-1:0] idx [8];
		logic [CFG_DATA_BITS-1:0]  val [8];
		logic [23:0]               junk;
		junk = chance(50) ? 24'($urandom()) : 24'd0;
		idx  = '{REG_COARSE_BUDGET, REG_CODE_BUDGET, REG_SHAPE_BUDGET, REG_STABLE_HOLD,
			REG_TOTAL_BUDGET, REG_CAND_FRAMES, REG_SHAPE_FRAMES, REG_PHASE_FRAMES};
		val  = '{c.coarse_ticks, c.code_ticks, c.shape_ticks, c.hold_ticks,
			c.total_budget, {junk, c.cand_frames},
			{junk, c.shape_frames}, {junk, c.phase_frames}};
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Program a setting, restart the sequencer and stream random frames at it.
	task automatic run_acquisition_phase(input cfg_t c, input int n, input int good_pct,
			input int noise_pct, input int upset_pct, input int pressure_at);
		program_budgets(c);
		send_frame(make_frame(1'b1, tick, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		for (int k = 0; k < n; k++) begin
			if (k == pressure_at)
				hold_off_req = 1'b1;
			send_frame(random_frame(good_pct, noise_pct, upset_pct));
		end
		drain_results();
	endtask

	// Result side: random stalls, plus the one long hold-off when asked for.
	initial begin
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (quiet || chance(70)) begin
				out_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b0;
				repeat (pick_gap() + 1) @(posedge clk);
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		tick         = '0;
		hold_off_req = 1'b0;
		quiet        = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: zero budgets, so any tick past the start is a total timeout.
		// The first update reports the mode enter event left pending by reset.
		send_frame(make_frame(1'b0, 32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd5, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		// Failed past the total budget: the total timeout repeats on every update.
		send_frame(make_frame(1'b0, 32'd6, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		// Source change out of failed re-enters coarse frequency.
		send_frame(make_frame(1'b0, 32'd6, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		drain_results();

		// Walk the full ladder by hand with short budgets and a two-frame candidate run.
		program_budgets(cfg_t'{32'd5, 32'd5, 32'd5, 32'd3, 32'd100, 8'd2, 8'd1, 8'd1});
		send_frame(make_frame(1'b1, 32'd1000, 1'b0, 1'b0, 1'b0, 1'b0, 16'h8000, 1'b0, 1'b0));
		// Source change in mode enter is ignored.
		send_frame(make_frame(1'b0, 32'd1000, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1001, 1'b0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1002, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1003, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1004, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0, 1'b0));
		// Margin one below the threshold fails, the threshold itself passes.
		send_frame(make_frame(1'b0, 32'd1005, 1'b0, 1'b0, 1'b0, 1'b1, 16'd40, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1006, 1'b0, 1'b0, 1'b0, 1'b1, 16'd41, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1007, 1'b0, 1'b0, 1'b0, 1'b1, 16'd41, 1'b0, 1'b0));
		// Candidate rejected on a missing code estimate.
		send_frame(make_frame(1'b0, 32'd1008, 1'b0, 1'b0, 1'b0, 1'b0, 16'd41, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1009, 1'b0, 1'b0, 1'b0, 1'b1, 16'h7FFF, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1010, 1'b0, 1'b0, 1'b0, 1'b1, 16'h7FFF, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1011, 1'b0, 1'b0, 1'b0, 1'b1, 16'h7FFF, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1012, 1'b0, 1'b0, 1'b0, 1'b1, 16'h7FFF, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1013, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0));
		send_frame(make_frame(1'b0, 32'd1014, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1));
		// Stable reset on a lost phase, then stable pass once the hold has elapsed.
		send_frame(make_frame(1'b0, 32'd1015, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1, 1'b0));
		send_frame(make_frame(1'b0, 32'd1016, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1, 1'b1));
		send_frame(make_frame(1'b0, 32'd1019, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1, 1'b1));
		send_frame(make_frame(1'b0, 32'd1020, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b1, 1'b1));
		// Back to phase track, then a stage timeout.
		send_frame(make_frame(1'b0, 32'd1030, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1));
		send_frame(make_frame(1'b0, 32'd1040, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 32'd1200, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		// Source change wins over the total timeout.
		send_frame(make_frame(1'b0, 32'd1200, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0));
		send_frame(make_frame(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 16'hFFFF,
			1'b1, 1'b1));
		drain_results();

		// Moderate budgets; hold off the result side partway through.
		tick = 32'd5000;
		run_acquisition_phase(cfg_t'{32'd40, 32'd60, 32'd80, 32'd20, 32'd400,
			8'd3, 8'd2, 8'd3}, 220, 90, 5, 3, 50);

		// Zero stage budgets and zero confirm counts; no idling on either side.
		quiet = 1'b1;
		run_acquisition_phase(cfg_t'{32'd0, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF,
			8'd0, 8'd0, 8'd0}, 120, 85, 5, 2, -1);
		quiet = 1'b0;

		// All-ones budgets: the deadline lands one tick behind the entry time.
		run_acquisition_phase(cfg_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255}, 80, 70, 30, 5, -1);

		// Clean frames only: run the shape count all the way to its maximum.
		run_acquisition_phase(cfg_t'{32'd1000, 32'd1000, 32'd100000, 32'd50, 32'h7FFF_FFFF,
			8'd1, 8'd255, 8'd40}, 330, 100, 0, 0, -1);

		// Random small settings, with the time base wrapping through zero.
		tick = 32'hFFFF_FF00;
		run_acquisition_phase(cfg_t'{32'($urandom_range(10, 200)), 32'($urandom_range(10, 200)),
			32'($urandom_range(10, 200)), 32'($urandom_range(0, 40)),
			32'($urandom_range(200, 2000)), 8'($urandom_range(1, 6)),
			8'($urandom_range(1, 6)), 8'($urandom_range(1, 6))}, 300, 80, 10, 4, -1);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb_acquisition_lock_sequencer passed");
		else
			$display("tb_acquisition_lock_sequencer failed");
		$finish;
	end

endmodule

// File: files.f
src/als_pkg.sv
src/als_if.sv
src/als_cfg_regs.sv
src/als_step_core.sv
src/acquisition_lock_sequencer.sv
bench/als_sequence_checker.sv
bench/tb_acquisition_lock_sequencer.sv
